// ===== design/crh_pkg.sv =====
// ----------------------------------------------------------------------------
// crh_pkg: shared types and constants for the range/heading converter
// Beat types, CORDIC angle table and fixed-point constants.
// ----------------------------------------------------------------------------
package crh_pkg;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_in_beat;

    typedef struct packed {
        logic        [15:0] distance;
        logic signed [15:0] heading;
    } t_out_beat;

    // Control that travels alongside the data in every stage
    typedef struct packed {
        logic valid;
        logic origin;
    } t_ctl;

    localparam int GUARD_BITS  = 8;
    localparam int Z_W         = 21;        // Q.16 angle accumulator
    localparam int TABLE_LEN   = 24;
    localparam int PI_Q16      = 205887;
    localparam int PI_Q13      = 25736;
    localparam int HALF_PI_Q13 = 12868;
    localparam int GAIN_Q23    = 5094007;
    localparam int GAIN_W      = 23;
    // Magnitudes at or above 2^XC_W saturate the range anyway
    localparam int XC_W        = 25;
    localparam int XC_MAX      = (1 << XC_W) - 1;
    localparam int P_W         = XC_W + GAIN_W;
    localparam int RND_SHIFT   = GUARD_BITS + 23;

    function automatic logic signed [Z_W-1:0] f_atan(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(51472);
            5'd1:    v = Z_W'(30386);
            5'd2:    v = Z_W'(16055);
            5'd3:    v = Z_W'(8150);
            5'd4:    v = Z_W'(4091);
            5'd5:    v = Z_W'(2047);
            5'd6:    v = Z_W'(1024);
            5'd7:    v = Z_W'(512);
            5'd8:    v = Z_W'(256);
            5'd9:    v = Z_W'(128);
            5'd10:   v = Z_W'(64);
            5'd11:   v = Z_W'(32);
            5'd12:   v = Z_W'(16);
            5'd13:   v = Z_W'(8);
            5'd14:   v = Z_W'(4);
            5'd15:   v = Z_W'(2);
            5'd16:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/cartesian_to_range_heading.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_range_heading: offset (x, y) to range and heading
// Pipelined CORDIC vectoring chain giving the Euclidean length and the
// angle from the +y axis in Q3.13 radians, wrapped to plus/minus pi.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+------------------------------
//   in      | input     | t_in_beat   | i_in_valid / o_in_stall
//   out     | output    | t_out_beat  | o_out_valid / i_out_stall
//
// One beat is taken every cycle while the output is not stalled; a beat
// passes the input cell, one cell per micro-rotation and the gain and
// heading stages of crh_back. Reset clears all valid bits; no clearing
// pass. A stall on the output freezes the whole chain and is passed to
// the input side in the same cycle while the output register is full.
// ----------------------------------------------------------------------------
module cartesian_to_range_heading
    import crh_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int XW    = COORD_WIDTH + 11;
    localparam int STEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    logic                  en;
    logic                  out_valid;
    t_ctl                  ctl_c [0:STEPS];
    logic signed [XW-1:0]  x_c   [0:STEPS];
    logic signed [XW-1:0]  y_c   [0:STEPS];
    logic signed [Z_W-1:0] z_c   [0:STEPS];

    // Advance the chain unless a finished beat is held at the output
    assign en          = !out_valid || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = out_valid;

    crh_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .XW          (XW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_beat  (i_in_data),
        .o_ctl   (ctl_c[0]),
        .o_x     (x_c[0]),
        .o_y     (y_c[0]),
        .o_z     (z_c[0])
    );

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        crh_cell #(
            .XW  (XW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl_c[g]),
            .i_x     (x_c[g]),
            .i_y     (y_c[g]),
            .i_z     (z_c[g]),
            .o_ctl   (ctl_c[g+1]),
            .o_x     (x_c[g+1]),
            .o_y     (y_c[g+1]),
            .o_z     (z_c[g+1])
        );
    end

    crh_back #(
        .XW (XW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl_c[STEPS]),
        .i_x     (x_c[STEPS]),
        .i_z     (z_c[STEPS]),
        .o_valid (out_valid),
        .o_beat  (o_out_data)
    );

endmodule

// ===== design/crh_front.sv =====
// ----------------------------------------------------------------------------
// crh_front: input cell
// Sign-interprets the coordinates, rotates the left half-plane by pi and
// scales up by the guard bits.
// ----------------------------------------------------------------------------
module crh_front
    import crh_pkg::*;
#(
    parameter int COORD_WIDTH = 16,
    parameter int XW          = COORD_WIDTH + 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  t_in_beat             i_beat,
    output t_ctl                 o_ctl,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic signed [Z_W-1:0] o_z
);

    localparam int RW = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;

    logic [RW-1:0]                 raw_x;
    logic [RW-1:0]                 raw_y;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH:0]   ex;
    logic signed [COORD_WIDTH:0]   ey;
    logic                          neg;
    t_ctl                          r_ctl;
    t_ctl                          n_ctl;
    logic signed [XW-1:0]          r_x, n_x;
    logic signed [XW-1:0]          r_y, n_y;
    logic signed [Z_W-1:0]         r_z, n_z;

    always_comb begin
        raw_x = RW'($unsigned(i_beat.pos_x));
        raw_y = RW'($unsigned(i_beat.pos_y));
        cx    = $signed(raw_x[COORD_WIDTH-1:0]);
        cy    = $signed(raw_y[COORD_WIDTH-1:0]);
        neg   = cx[COORD_WIDTH-1];
        ex    = (COORD_WIDTH+1)'(cx);
        ey    = (COORD_WIDTH+1)'(cy);
        if (neg) begin
            ex  = -ex;
            ey  = -ey;
            n_z = cy[COORD_WIDTH-1] ? -Z_W'(PI_Q16) : Z_W'(PI_Q16);
        end else begin
            n_z = '0;
        end
        n_x          = XW'(ex) <<< GUARD_BITS;
        n_y          = XW'(ey) <<< GUARD_BITS;
        n_ctl.valid  = i_valid;
        n_ctl.origin = (cx == '0) && (cy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== design/crh_cell.sv =====
// ----------------------------------------------------------------------------
// crh_cell: one CORDIC vectoring micro-rotation
// Rotates toward the x axis by atan(2^-IDX) and hands the result on.
// ----------------------------------------------------------------------------
module crh_cell
    import crh_pkg::*;
#(
    parameter int XW  = 27,
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [Z_W-1:0] i_z,
    output t_ctl                  o_ctl,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic signed [Z_W-1:0] o_z
);

    logic signed [XW-1:0]  xs;
    logic signed [XW-1:0]  ys;
    logic signed [Z_W-1:0] ang;
    t_ctl                  r_ctl;
    logic signed [XW-1:0]  r_x, n_x;
    logic signed [XW-1:0]  r_y, n_y;
    logic signed [Z_W-1:0] r_z, n_z;

    always_comb begin
        xs  = i_x >>> IDX;
        ys  = i_y >>> IDX;
        ang = f_atan(5'(IDX));
        if (!i_y[XW-1]) begin
            n_x = i_x + ys;
            n_y = i_y - xs;
            n_z = i_z + ang;
        end else begin
            n_x = i_x - ys;
            n_y = i_y + xs;
            n_z = i_z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

// ===== design/crh_back.sv =====
// ----------------------------------------------------------------------------
// crh_back: gain correction and heading wrap
// Stage one clamps the magnitude and wraps the heading; stage two applies
// the CORDIC gain, rounds, saturates and holds the output beat.
// ----------------------------------------------------------------------------
module crh_back
    import crh_pkg::*;
#(
    parameter int XW = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [Z_W-1:0] i_z,
    output logic                  o_valid,
    output t_out_beat             o_beat
);

    localparam int CW = (XW > XC_W + 1) ? XW : XC_W + 1;

    logic [CW-1:0]       xe;
    logic [XC_W-1:0]     n_xc;
    logic signed [Z_W:0] zr;
    logic signed [Z_W:0] zs;
    logic signed [Z_W:0] hh;
    logic signed [15:0]  n_h;
    logic                r_v1;
    logic [XC_W-1:0]     r_xc;
    logic signed [15:0]  r_h;
    logic [P_W-1:0]      prod;
    logic [P_W-1:0]      sum;
    logic [P_W-RND_SHIFT-1:0] ds;
    logic [15:0]         n_d;
    logic                r_out_valid;
    t_out_beat           r_out;

    // Stage one: clamp magnitude, convert and wrap heading
    always_comb begin
        xe   = i_x[XW-1] ? '0 : CW'($unsigned(i_x));
        n_xc = (xe > CW'(XC_MAX)) ? XC_W'(XC_MAX) : xe[XC_W-1:0];
        zr   = (Z_W+1)'(i_z) + (Z_W+1)'(4);
        zs   = zr >>> 3;
        hh   = zs - (Z_W+1)'(HALF_PI_Q13);
        if (hh < -(Z_W+1)'(PI_Q13)) begin
            hh = hh + (Z_W+1)'(2 * PI_Q13);
        end
        if (hh < -(Z_W+1)'(PI_Q13)) begin
            hh = -(Z_W+1)'(PI_Q13);
        end
        if (hh > (Z_W+1)'(PI_Q13)) begin
            hh = (Z_W+1)'(PI_Q13);
        end
        n_h = i_ctl.origin ? -16'(HALF_PI_Q13) : 16'(hh);
    end

    // Stage two: gain, round half up, saturate
    always_comb begin
        prod = P_W'(r_xc) * P_W'(GAIN_Q23);
        sum  = prod + (P_W'(1) << (RND_SHIFT - 1));
        ds   = sum[P_W-1:RND_SHIFT];
        n_d  = (ds > (P_W-RND_SHIFT)'(16'hFFFF)) ? 16'hFFFF : ds[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_v1        <= i_ctl.valid;
            r_out_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xc           <= n_xc;
            r_h            <= n_h;
            r_out.distance <= n_d;
            r_out.heading  <= r_h;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: range/heading converter check
// Drives signed (x, y) offsets through the CORDIC chain and compares every
// output beat with a local fixed-point model of range and wrapped heading.
// Covers axes, origin, corners, diagonals and random offsets under several
// sender/receiver idle mixes plus a long output hold that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import crh_pkg::*;

    localparam int CORDIC_STEPS     = 16;
    localparam int COORD_WIDTH      = 16;
    localparam int LATENCY          = CORDIC_STEPS + 3;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD_CYCLES = 400;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_beat  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_beat o_out_data;

    t_out_beat pending_polar[$];
    longint    atan_q16_tab [0:23];
    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    logic      long_hold     = 1'b0;
    int        n_cycles      = 0;
    int        n_sent        = 0;
    int        n_results     = 0;
    int        n_errors      = 0;
    int        n_in_stalled  = 0;
    event      hold_off_go;

    cartesian_to_range_heading #(
        .CORDIC_STEPS(CORDIC_STEPS),
        .COORD_WIDTH (COORD_WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // atan(2^-k) in Q.16, rounded to nearest
    initial begin
        for (int k = 0; k < 24; k++)
            atan_q16_tab[k] = $rtoi($floor($atan(2.0 ** (-k)) * 65536.0 + 0.5));
    end

    function automatic t_out_beat polar_of(input t_in_beat beat);
        longint       x, y, z, xs, ys, hd;
        longint       mag;
        t_out_beat    r;
        x = beat.pos_x;
        y = beat.pos_y;
        z = 0;
        if (x == 0 && y == 0) begin
            r.distance = '0;
            r.heading  = 16'(-HALF_PI_Q13);
            return r;
        end
        // fold the left half plane onto the right one
        if (x < 0) begin
            z = (y >= 0) ? PI_Q16 : -PI_Q16;
            x = -x;
            y = -y;
        end
        x = x * (64'sd1 <<< GUARD_BITS);
        y = y * (64'sd1 <<< GUARD_BITS);
        for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_q16_tab[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_q16_tab[k];
            end
        end
        if (x < 0)
            x = 0;
        mag = (x * longint'(GAIN_Q23) + (64'sd1 <<< (GUARD_BITS + 22))) >>> (GUARD_BITS + 23);
        if (mag > 65535)
            mag = 65535;
        hd = ((z + 4) >>> 3) - HALF_PI_Q13;
        if (hd < -PI_Q13)
            hd = hd + 2 * PI_Q13;
        if (hd < -PI_Q13)
            hd = -PI_Q13;
        if (hd > PI_Q13)
            hd = PI_Q13;
        r.distance = mag[15:0];
        r.heading  = hd[15:0];
        return r;
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(5))
            0:       return 16'sh8000;
            1:       return 16'sh8001;
            2:       return -16'sd1;
            3:       return 16'sd0;
            4:       return 16'sd1;
            default: return 16'sh7fff;
        endcase
    endfunction

    // Offer one beat after a random idle gap; return at the accepting edge
    task automatic send_offset(input logic signed [15:0] px, input logic signed [15:0] py);
        t_in_beat beat;
        bit       taken;
        beat.pos_x = px;
        beat.pos_y = py;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            if (!taken)
                n_in_stalled++;
            @(posedge i_clk);
        end
        pending_polar.insert(pending_polar.size(), polar_of(beat));
        n_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_polar.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_offset(16'sd0, 16'sd0);
        send_offset(16'sd1, 16'sd0);
        send_offset(16'sd0, 16'sd1);
        send_offset(-16'sd1, 16'sd0);
        send_offset(16'sd0, -16'sd1);
        send_offset(16'sh7fff, 16'sd0);
        send_offset(16'sh8000, 16'sd0);
        send_offset(16'sd0, 16'sh7fff);
        send_offset(16'sd0, 16'sh8000);
        send_offset(16'sh7fff, 16'sh7fff);
        send_offset(16'sh8000, 16'sh8000);
        send_offset(16'sh8000, 16'sh7fff);
        send_offset(16'sh7fff, 16'sh8000);
        send_offset(16'sd1, 16'sd1);
        send_offset(-16'sd1, -16'sd1);
        send_offset(-16'sd1, 16'sd1);
        send_offset(16'sd1, -16'sd1);
        send_offset(-16'sd200, -16'sd1);
        send_offset(-16'sd200, 16'sd1);
        send_offset(16'sd100, -16'sd3);
        send_offset(16'sd3000, 16'sd4000);
        send_offset(-16'sd12345, 16'sd321);
        drain();
    endtask

    task automatic test_random(input int n, input int send_pct, input int hold_pct);
        logic signed [15:0] px, py;
        int                 m;
        send_idle_pct = send_pct;
        stall_pct     = hold_pct;
        repeat (n) begin
            m = $urandom_range(32767);
            case ($urandom_range(9))
                4: begin
                    px = 16'(int'($urandom_range(64)) - 32);
                    py = 16'(int'($urandom_range(64)) - 32);
                end
                5: begin
                    if ($urandom_range(1)) begin
                        px = 16'($urandom);
                        py = 16'sd0;
                    end else begin
                        px = 16'sd0;
                        py = 16'($urandom);
                    end
                end
                6: begin
                    px = pick_extreme();
                    py = pick_extreme();
                end
                7: begin
                    px = $urandom_range(1) ? 16'(m) : 16'(-m);
                    py = $urandom_range(1) ? 16'(m) : 16'(-m);
                end
                // just around the negative x axis, where the wrap happens
                8: begin
                    px = 16'(-int'($urandom_range(32768, 1)));
                    py = 16'(int'($urandom_range(4)) - 2);
                end
                9: begin
                    px = $urandom_range(1) ? 16'($urandom_range(32767, 24576))
                                           : 16'(-int'($urandom_range(32768, 24576)));
                    py = 16'($urandom);
                end
                default: begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
            endcase
            send_offset(px, py);
        end
        drain();
    endtask

    // Hold the output for a long stretch while the sender keeps offering
    task automatic test_long_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        -> hold_off_go;
        repeat (60)
            send_offset(16'($urandom), 16'($urandom));
        drain();
    endtask

    always begin
        @(hold_off_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_stall <= 1'b0;
        else
            i_out_stall <= long_hold || ($urandom_range(99) < stall_pct);
    end

    // Outputs settle by the falling edge and hold through the next rising edge
    always @(negedge i_clk) begin : check_result
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_polar.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected beat, expected none, actual distance=%0d heading=%0d",
                         $time, o_out_data.distance, o_out_data.heading);
            end else begin
                want = pending_polar.pop_front();
                if (o_out_data.distance !== want.distance) begin
                    n_errors++;
                    $display("%0t: distance mismatch, expected %0d, actual %0d",
                             $time, want.distance, o_out_data.distance);
                end
                if (o_out_data.heading !== want.heading) begin
                    n_errors++;
                    $display("%0t: heading mismatch, expected %0d, actual %0d",
                             $time, want.heading, o_out_data.heading);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still outstanding",
                     n_cycles, pending_polar.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(360, 0, 0);
        test_random(360, 81, 0);
        test_random(360, 0, 81);
        test_random(300, 31, 31);
        test_long_hold();
        $display("Checked %0d range/heading beats from %0d offsets; input held off %0d cycles.",
                 n_results, n_sent, n_in_stalled);
        $display("Origin, axes, corners, diagonals and random offsets, four idle mixes, long hold.");
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
